[rtl/core/bps_pkg.sv]
package bps_pkg;

    // Item codes on the command channel
    localparam logic [2:0] MODE_TICK = 3'd0;
    localparam logic [2:0] MODE_ON   = 3'd1;
    localparam logic [2:0] MODE_OFF  = 3'd2;
    localparam logic [2:0] MODE_BEEP = 3'd3;
    localparam logic [2:0] MODE_PLAY = 3'd4;

    // Pattern selects
    localparam logic [1:0] PAT_SUCCESS  = 2'd0;
    localparam logic [1:0] PAT_FAILURE  = 2'd1;
    localparam logic [1:0] PAT_REGISTER = 2'd2;

    // Longest pattern the sequencer will run; longer tables get cut
    localparam int MAX_STEPS = 8;

    localparam int STEP_CNT_W = 4;
    localparam int STEP_IDX_W = 3;
    localparam int TIME_W     = 16;

    typedef logic [STEP_CNT_W-1:0] step_cnt_t;
    typedef logic [STEP_IDX_W-1:0] step_idx_t;
    typedef logic [TIME_W-1:0]     ms_t;

    typedef struct packed {
        logic [2:0] mode;
        ms_t        duration;
        logic [1:0] pattern_select;
    } cmd_item_t;

    typedef struct packed {
        logic buzzer_on;
        logic busy_res;
    } res_item_t;

    // Number of steps in a pattern, clipped to MAX_STEPS; zero for an unused select
    function automatic step_cnt_t pattern_len(input logic [1:0] pat);
        step_cnt_t len;
        case (pat)
            PAT_SUCCESS:  len = step_cnt_t'(3);
            PAT_FAILURE:  len = step_cnt_t'(3);
            PAT_REGISTER: len = step_cnt_t'(5);
            default:      len = step_cnt_t'(0);
        endcase
        if (len > step_cnt_t'(MAX_STEPS))
            len = step_cnt_t'(MAX_STEPS);
        return len;
    endfunction

    // Length in ms of one step of a built-in pattern
    function automatic ms_t step_time(input logic [1:0] pat, input step_idx_t idx);
        ms_t t;
        t = '0;
        case (pat)
            PAT_SUCCESS:
            begin
                case (idx)
                    3'd0:    t = ms_t'(60);
                    3'd1:    t = ms_t'(40);
                    3'd2:    t = ms_t'(60);
                    default: t = '0;
                endcase
            end
            PAT_FAILURE:
            begin
                case (idx)
                    3'd0:    t = ms_t'(180);
                    3'd1:    t = ms_t'(70);
                    3'd2:    t = ms_t'(180);
                    default: t = '0;
                endcase
            end
            PAT_REGISTER:
            begin
                case (idx)
                    3'd0:    t = ms_t'(70);
                    3'd1:    t = ms_t'(40);
                    3'd2:    t = ms_t'(70);
                    3'd3:    t = ms_t'(40);
                    3'd4:    t = ms_t'(70);
                    default: t = '0;
                endcase
            end
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

[rtl/core/bps_cmd_if.sv]
interface bps_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] duration;
    logic [1:0]  pattern_select;

    modport source (output valid, output mode, output duration, output pattern_select,
                    input ready);
    modport sink   (input valid, input mode, input duration, input pattern_select,
                    output ready);
endinterface

[rtl/core/bps_res_if.sv]
interface bps_res_if;
    logic valid;
    logic ready;
    logic buzzer_on;
    logic busy_res;

    modport source (output valid, output buzzer_on, output busy_res, input ready);
    modport sink   (input valid, input buzzer_on, input busy_res, output ready);
endinterface

[rtl/core/beep_pattern_sequencer_top.sv]
// Buzzer sequencer. Each command transaction (tick, on, off, beep, play) yields exactly one
// result transaction carrying the buzzer level and a busy flag after that command. The block
// takes one transaction per cycle when the pipe is not stalled. Inside the pipe, an input register
// holds the command, one short pass of compare/increment logic updates the mode state, and a
// result register holds the answer. The result register decouples the two sides, so a new
// command enters while a result waits; the pipe stalls only when both stages are full and
// the result sink holds ready low. Pattern step times come from a constant table indexed by
// the loaded pattern and the step number. Write enable through cfg_we/cfg_wdata only while
// no transaction is in flight; every write also drives the buzzer level low.
module beep_pattern_sequencer_top
    import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    bps_cmd_if.sink     cmd,
    bps_res_if.source   res
);

    // Input stage
    logic      in_valid_reg;
    cmd_item_t in_item_reg;

    // Result stage
    logic      out_valid_reg;
    res_item_t out_item_reg;
    res_item_t out_item_next;

    // Mode state
    logic      enable_reg;
    logic      level_reg,      level_next;
    logic      beep_run_reg,   beep_run_next;
    ms_t       beep_len_reg,   beep_len_next;
    ms_t       elapsed_reg,    elapsed_next;
    step_cnt_t step_cnt_reg,   step_cnt_next;
    step_idx_t step_idx_reg,   step_idx_next;
    logic [1:0] pat_reg,       pat_next;

    logic advance;
    logic process;

    // The input stage moves on when the result slot is free or being drained
    assign advance   = !out_valid_reg || res.ready;
    assign process   = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_item_reg.mode           <= cmd.mode;
            in_item_reg.duration       <= cmd.duration;
            in_item_reg.pattern_select <= cmd.pattern_select;
        end
    end

    // One pass of the sequencer for the held command
    always_comb
    begin
        ms_t       elapsed_inc;
        step_idx_t idx_inc;
        step_cnt_t pat_len;

        level_next    = level_reg;
        beep_run_next = beep_run_reg;
        beep_len_next = beep_len_reg;
        elapsed_next  = elapsed_reg;
        step_cnt_next = step_cnt_reg;
        step_idx_next = step_idx_reg;
        pat_next      = pat_reg;

        // Saturate the ms counter at all ones
        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ms_t'(1);
        idx_inc     = step_idx_reg + step_idx_t'(1);
        pat_len     = pattern_len(in_item_reg.pattern_select);

        case (in_item_reg.mode)
            MODE_TICK:
            begin
                if (enable_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (beep_run_reg)
                    begin
                        if (elapsed_inc >= beep_len_reg)
                        begin
                            beep_run_next = 1'b0;
                            level_next    = 1'b0;
                        end
                    end
                    else if (step_cnt_reg != '0 &&
                             elapsed_inc >= step_time(pat_reg, step_idx_reg))
                    begin
                        // Step done: restart the timer and move to the next step
                        elapsed_next = '0;
                        if (step_cnt_t'(idx_inc) >= step_cnt_reg)
                        begin
                            step_cnt_next = '0;
                            step_idx_next = '0;
                            level_next    = 1'b0;
                        end
                        else
                        begin
                            step_idx_next = idx_inc;
                            level_next    = ~idx_inc[0];
                        end
                    end
                end
            end
            MODE_ON:
            begin
                step_cnt_next = '0;
                step_idx_next = '0;
                beep_run_next = 1'b0;
                if (enable_reg)
                    level_next = 1'b1;
            end
            MODE_OFF:
            begin
                step_cnt_next = '0;
                step_idx_next = '0;
                beep_run_next = 1'b0;
                if (enable_reg)
                    level_next = 1'b0;
            end
            MODE_BEEP:
            begin
                step_cnt_next = '0;
                step_idx_next = '0;
                beep_run_next = 1'b1;
                beep_len_next = in_item_reg.duration;
                elapsed_next  = '0;
                if (enable_reg)
                    level_next = 1'b1;
            end
            MODE_PLAY:
            begin
                beep_run_next = 1'b0;
                step_idx_next = '0;
                step_cnt_next = pat_len;
                if (pat_len == '0)
                begin
                    // Unused select: cancel and go quiet
                    if (enable_reg)
                        level_next = 1'b0;
                end
                else
                begin
                    pat_next     = in_item_reg.pattern_select;
                    elapsed_next = '0;
                    if (enable_reg)
                        level_next = 1'b1;
                end
            end
            default:
            begin
                // Unused codes leave the state alone
            end
        endcase

        out_item_next.buzzer_on = level_next & enable_reg;
        out_item_next.busy_res  = beep_run_next | (step_cnt_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            level_reg    <= 1'b0;
            beep_run_reg <= 1'b0;
            beep_len_reg <= '0;
            elapsed_reg  <= '0;
            step_cnt_reg <= '0;
            step_idx_reg <= '0;
            pat_reg      <= PAT_SUCCESS;
        end
        else if (cfg_we)
        begin
            // Configuring the pin drives it low
            enable_reg <= cfg_wdata;
            level_reg  <= 1'b0;
        end
        else if (process)
        begin
            level_reg    <= level_next;
            beep_run_reg <= beep_run_next;
            beep_len_reg <= beep_len_next;
            elapsed_reg  <= elapsed_next;
            step_cnt_reg <= step_cnt_next;
            step_idx_reg <= step_idx_next;
            pat_reg      <= pat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.buzzer_on = out_item_reg.buzzer_on;
    assign res.busy_res  = out_item_reg.busy_res;

endmodule

[dv/beep_pattern_sequencer_top_checker.sv]
`timescale 1ns / 100ps

module beep_pattern_sequencer_top_checker
    import bps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    bps_cmd_if   cmd,
    bps_res_if   res,
    output int   fail_count,
    output int   outstanding
);

    // Shadow copy of the sequencer state
    logic       enable_q;
    logic       level_q;
    logic       beep_active;
    ms_t        beep_ms;
    ms_t        elapsed_ms;
    step_cnt_t  steps_loaded;
    step_idx_t  step_pos;
    ms_t        step_ms [MAX_STEPS];

    // Buzzer level and busy flag owed for each accepted command, oldest first
    res_item_t  level_busy_q [$];

    function automatic void set_level(input logic lvl);
        if (enable_q)
            level_q = lvl;
    endfunction

    function automatic void clear_run();
        steps_loaded = '0;
        step_pos     = '0;
        beep_active  = 1'b0;
    endfunction

    function automatic res_item_t buzzer_after(input cmd_item_t c);
        res_item_t r;
        step_cnt_t n;
        n = '0;
        case (c.mode)
            MODE_TICK:
            begin
                if (enable_q)
                begin
                    if (elapsed_ms != '1)
                        elapsed_ms = elapsed_ms + 1'b1;
                    if (beep_active)
                    begin
                        if (elapsed_ms >= beep_ms)
                        begin
                            beep_active = 1'b0;
                            set_level(1'b0);
                        end
                    end
                    else if (steps_loaded != '0 && elapsed_ms >= step_ms[step_pos])
                    begin
                        // Step time used up: move on, odd steps are silent
                        elapsed_ms = '0;
                        step_pos   = step_pos + 1'b1;
                        if ({1'b0, step_pos} >= steps_loaded)
                        begin
                            steps_loaded = '0;
                            step_pos     = '0;
                            set_level(1'b0);
                        end
                        else
                            set_level(~step_pos[0]);
                    end
                end
            end
            MODE_ON:
            begin
                clear_run();
                set_level(1'b1);
            end
            MODE_OFF:
            begin
                clear_run();
                set_level(1'b0);
            end
            MODE_BEEP:
            begin
                clear_run();
                beep_active = 1'b1;
                beep_ms     = c.duration;
                elapsed_ms  = '0;
                set_level(1'b1);
            end
            MODE_PLAY:
            begin
                clear_run();
                case (c.pattern_select)
                    PAT_SUCCESS:
                    begin
                        step_ms[0] = 16'd60;
                        step_ms[1] = 16'd40;
                        step_ms[2] = 16'd60;
                        n = 4'd3;
                    end
                    PAT_FAILURE:
                    begin
                        step_ms[0] = 16'd180;
                        step_ms[1] = 16'd70;
                        step_ms[2] = 16'd180;
                        n = 4'd3;
                    end
                    PAT_REGISTER:
                    begin
                        step_ms[0] = 16'd70;
                        step_ms[1] = 16'd40;
                        step_ms[2] = 16'd70;
                        step_ms[3] = 16'd40;
                        step_ms[4] = 16'd70;
                        n = 4'd5;
                    end
                    default:
                        n = '0;
                endcase
                if (n == '0)
                    set_level(1'b0);
                else
                begin
                    if (n > MAX_STEPS)
                        n = step_cnt_t'(MAX_STEPS);
                    steps_loaded = n;
                    step_pos     = '0;
                    elapsed_ms   = '0;
                    set_level(1'b1);
                end
            end
            default:
            begin
            end
        endcase
        r.buzzer_on = level_q & enable_q;
        r.busy_res  = beep_active | (steps_loaded != '0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_item_t want;
        res_item_t got;
        cmd_item_t c;
        if (!rst_n)
        begin
            enable_q     = 1'b0;
            level_q      = 1'b0;
            beep_active  = 1'b0;
            beep_ms      = '0;
            elapsed_ms   = '0;
            steps_loaded = '0;
            step_pos     = '0;
            for (int i = 0; i < MAX_STEPS; i++)
                step_ms[i] = '0;
            level_busy_q.delete();
            fail_count   = 0;
            outstanding  = 0;
        end
        else
        begin
            // Any enable write also pulls the output level low
            if (cfg_we)
            begin
                enable_q = cfg_wdata;
                level_q  = 1'b0;
            end
            if (res.valid && res.ready)
            begin
                got.buzzer_on = res.buzzer_on;
                got.busy_res  = res.busy_res;
                if (level_busy_q.size() == 0)
                begin
                    $error("unexpected result transaction: buzzer_on %0b busy_res %0b",
                           got.buzzer_on, got.busy_res);
                    fail_count++;
                end
                else
                begin
                    want = level_busy_q.pop_front();
                    if (got.buzzer_on !== want.buzzer_on)
                    begin
                        $error("buzzer_on: expected %0b, got %0b",
                               want.buzzer_on, got.buzzer_on);
                        fail_count++;
                    end
                    if (got.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0b, got %0b",
                               want.busy_res, got.busy_res);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                c.mode           = cmd.mode;
                c.duration       = cmd.duration;
                c.pattern_select = cmd.pattern_select;
                level_busy_q.push_back(buzzer_after(c));
            end
            outstanding = level_busy_q.size();
        end
    end

endmodule

[dv/beep_pattern_sequencer_top_tb.sv]
`timescale 1ns / 100ps

module beep_pattern_sequencer_top_tb;
    import bps_pkg::*;

    // Mode and pattern codes the block has no use for
    localparam logic [2:0] MODE_RSVD_LO = 3'd5;
    localparam logic [2:0] MODE_RSVD_HI = 3'd7;
    localparam logic [1:0] PAT_NONE     = 2'd3;

    localparam int RESET_CYCLES   = 11;
    // Two-stage pipe: settle time that covers any transaction still inside
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    bps_cmd_if cmd_ch ();
    bps_res_if res_ch ();

    int   fail_count;
    int   outstanding;
    int   cmds_sent;
    int   burst_left;
    int   stall_left;
    int   idle_cycles;
    logic tx_gaps;
    logic rx_stalls;

    beep_pattern_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    beep_pattern_sequencer_top_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // Result sink: drop ready for short random windows while stalls are on,
    // otherwise hold it high.
    always @(negedge clk)
    begin
        if (!rst_n || !rx_stalls)
            res_ch.ready <= rst_n;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Watchdog: abort once no transaction has moved on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("beep_pattern_sequencer_top regression: fail");
                    $finish;
                end
            end
        end
    end

    // Offer one command transaction and hold it until it is taken. Enter and
    // leave at a falling edge. While gaps are on, open a new burst with a
    // random pause once the current one runs out.
    task automatic send_cmd(input logic [2:0] m, input ms_t d, input logic [1:0] s);
        int gap;
        if (tx_gaps && burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        cmd_ch.valid          <= 1'b1;
        cmd_ch.mode           <= m;
        cmd_ch.duration       <= d;
        cmd_ch.pattern_select <= s;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        cmds_sent++;
        @(negedge clk);
    endtask

    // Tick with random junk in the unused payload fields
    task automatic send_ticks(input int count);
        repeat (count) send_cmd(MODE_TICK, ms_t'($urandom), 2'($urandom_range(0, 3)));
    endtask

    // Stop offering commands until every result transaction has come back.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Write the enable register only with the pipe empty and settled.
    task automatic write_enable(input logic v);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random traffic, mostly well-formed: start a pattern or a beep and feed it
    // enough ticks to run through, or cut it short. Sprinkle on/off and junk.
    task automatic run_random(input int n_items);
        int   stop_at;
        int   kind;
        int   ticks;
        ms_t  dur;
        stop_at = cmds_sent + n_items;
        while (cmds_sent < stop_at)
        begin
            if ($urandom_range(0, 39) == 0)
                drain_results();
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                send_cmd(MODE_PLAY, ms_t'($urandom), 2'($urandom_range(0, 2)));
                // success takes 160 ticks, register 290, failure 430
                if ($urandom_range(0, 2) == 0)
                    ticks = $urandom_range(0, 80);
                else
                    ticks = $urandom_range(150, 440);
            end
            else if (kind <= 6)
            begin
                case ($urandom_range(0, 9))
                    0:       dur = ms_t'($urandom);
                    1, 2, 3: dur = ms_t'($urandom_range(0, 300));
                    default: dur = ms_t'($urandom_range(0, 30));
                endcase
                send_cmd(MODE_BEEP, dur, 2'($urandom_range(0, 3)));
                ticks = $urandom_range(0, 40);
            end
            else if (kind == 7)
            begin
                send_cmd(($urandom_range(0, 1) == 0) ? MODE_ON : MODE_OFF,
                         ms_t'($urandom), 2'($urandom_range(0, 3)));
                ticks = $urandom_range(0, 8);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_cmd(3'($urandom_range(0, 7)), ms_t'($urandom),
                             2'($urandom_range(0, 3)));
                ticks = $urandom_range(0, 20);
            end
            // Keep the tick run inside this section's budget
            if (ticks > stop_at - cmds_sent)
                ticks = (stop_at > cmds_sent) ? stop_at - cmds_sent : 0;
            send_ticks(ticks);
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.mode           = MODE_TICK;
        cmd_ch.duration       = '0;
        cmd_ch.pattern_select = PAT_SUCCESS;
        cmds_sent             = 0;
        burst_left            = 0;
        tx_gaps               = 1'b1;
        rx_stalls             = 1'b1;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Disabled: output must read low, ticks are dead, but commands still
        // load beep and pattern state.
        write_enable(1'b0);
        send_cmd(MODE_ON, '0, PAT_SUCCESS);
        send_cmd(MODE_BEEP, 16'd3, PAT_SUCCESS);
        send_ticks(2);
        send_cmd(MODE_PLAY, '0, PAT_SUCCESS);
        send_ticks(1);

        // Enable with the success pattern loaded silently: its steps now advance
        // with the level held low until a command drives it.
        write_enable(1'b1);
        send_cmd(MODE_OFF, '1, PAT_NONE);
        send_cmd(MODE_ON, '0, PAT_SUCCESS);
        // Zero-length beep ends on the first tick
        send_cmd(MODE_BEEP, '0, PAT_SUCCESS);
        send_ticks(1);
        send_cmd(MODE_BEEP, '1, PAT_FAILURE);
        send_cmd(MODE_OFF, '0, PAT_SUCCESS);
        send_cmd(MODE_BEEP, 16'd2, PAT_SUCCESS);
        send_ticks(3);
        // Unused pattern select cancels and goes quiet
        send_cmd(MODE_PLAY, '0, PAT_NONE);
        send_cmd(MODE_PLAY, '0, PAT_REGISTER);
        send_cmd(MODE_ON, '0, PAT_SUCCESS);
        send_cmd(MODE_PLAY, '1, PAT_FAILURE);
        // Unused modes leave the state alone
        send_cmd(MODE_RSVD_LO, '0, PAT_SUCCESS);
        send_cmd(MODE_RSVD_HI, '1, PAT_NONE);
        send_cmd(MODE_ON, '0, PAT_SUCCESS);

        // Rewrite enable with the buzzer on: the write alone must silence it.
        write_enable(1'b1);
        send_ticks(1);

        // Longest beep, held across a run of ticks.
        send_cmd(MODE_BEEP, '1, PAT_SUCCESS);
        send_ticks(20);

        // Hold off until the pipe is empty before the random traffic.
        drain_results();
        run_random(300);

        write_enable(1'b0);
        run_random(100);

        // Back-to-back stretch: no sender gaps, no sink stalls.
        write_enable(1'b1);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_random(200);

        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        write_enable(1'b1);
        run_random(250);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("beep_pattern_sequencer_top regression: pass");
        else
            $display("beep_pattern_sequencer_top regression: fail");
        $finish;
    end

endmodule
